@@ rtl/bounding_box_moving_average_defines.svh @@
// Assertion macros shared by the bounding box smoothing RTL.
`ifndef BOUNDING_BOX_MOVING_AVERAGE_DEFINES_SVH
`define BOUNDING_BOX_MOVING_AVERAGE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BBMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BBMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bbma_pkg.sv @@
// Shared types and constants of the bounding box smoothing block.
`timescale 1ns / 1ps

package bbma_pkg;

  localparam int COORD_FIELD_BITS   = 12;
  localparam int SCALE_BITS         = 4;
  localparam int WINDOW_DEFAULT     = 30;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 4'd3;

  // Order in which the four results go through the shared divider.
  localparam logic [1:0] CH_X = 2'd0;
  localparam logic [1:0] CH_Y = 2'd1;
  localparam logic [1:0] CH_W = 2'd2;
  localparam logic [1:0] CH_H = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/bbma_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module bbma_div #(
  parameter int DVD_BITS = 21,
  parameter int DVS_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_BITS-1:0]   dividend,
  input  logic [DVS_BITS-1:0]   divisor,
  output bbma_pkg::div_status_t status,
  output logic [DVD_BITS-1:0]   quotient
);
  import bbma_pkg::*;

  localparam int CNT_W = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0] dvd_sh;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   diff;
  logic                take;

  always_comb begin
    rem_sh = {rem, dvd_sh[DVD_BITS-1]};
    diff   = rem_sh - {1'b0, dvs};
    // No borrow out of the top bit means the divisor fits.
    take   = ~diff[DVS_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sh <= dividend;
      dvs    <= divisor;
      rem    <= '0;
    end else if (busy) begin
      dvd_sh <= {dvd_sh[DVD_BITS-2:0], take};
      rem    <= take ? diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = dvd_sh;

endmodule

@@ rtl/bounding_box_moving_average.sv @@
// Top level: moving average of face boxes with a shared sequential divider.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  input   | in        | in_valid / in_stall   | box_x, box_y, box_width, box_height
//  result  | out       | out_valid / out_stall | mean_x, mean_y, scaled_width,
//          |           |                       | scaled_height
//  config  | in        | cfg_valid / cfg_ready | size_scale_tenths
//
// One box passes UPDATE, then LOAD and WAIT once for each of the four results on
// the one-bit-per-cycle divider, then DONE; the divider sets how long it takes.
// in_stall is high from the box's update until the results reach the output
// register. A stalled result holds in that register while the next box is taken.
// Reset is synchronous; the box histories need no clearing pass.
`timescale 1ns / 1ps

module bounding_box_moving_average #(
  parameter int WINDOW     = bbma_pkg::WINDOW_DEFAULT,
  parameter int COORD_BITS = bbma_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [bbma_pkg::COORD_FIELD_BITS-1:0]  box_x,
  input  logic [bbma_pkg::COORD_FIELD_BITS-1:0]  box_y,
  input  logic [bbma_pkg::COORD_FIELD_BITS-1:0]  box_width,
  input  logic [bbma_pkg::COORD_FIELD_BITS-1:0]  box_height,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bbma_pkg::COORD_FIELD_BITS-1:0]  mean_x,
  output logic [bbma_pkg::COORD_FIELD_BITS-1:0]  mean_y,
  output logic [bbma_pkg::COORD_FIELD_BITS-1:0]  scaled_width,
  output logic [bbma_pkg::COORD_FIELD_BITS-1:0]  scaled_height,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bbma_pkg::SCALE_BITS-1:0]        size_scale_tenths
);
  import bbma_pkg::*;

  `include "bounding_box_moving_average_defines.svh"

  localparam int CW        = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS
                                                             : COORD_FIELD_BITS;
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_BITS  = CW + CNT_BITS;
  localparam int DVD_BITS  = SUM_BITS + SCALE_BITS;
  localparam int DVS_BITS  = $clog2(10 * WINDOW + 1);
  localparam int OF        = COORD_FIELD_BITS;

  localparam logic [DVD_BITS-1:0] SAT_MAX =
    DVD_BITS'((64'd1 << COORD_BITS) - 64'd1);

  state_t state, state_next;

  logic [SCALE_BITS-1:0] scale;
  logic [CNT_BITS-1:0]   fill_count;
  logic [SLOT_BITS-1:0]  write_slot;
  logic [SUM_BITS-1:0]   sum_x, sum_y, sum_w, sum_h;
  logic [CW-1:0]         new_x, new_y, new_w, new_h;
  logic [4*CW-1:0]       history [WINDOW];
  logic [4*CW-1:0]       rd_word;
  logic [1:0]            ch;
  logic [OF-1:0]         res_x, res_y, res_w, res_h;

  logic                  in_accept;
  logic                  upd;
  logic                  div_start;
  logic                  cap;
  logic                  out_load;
  logic                  full;
  logic                  scaled_ch;
  logic [SUM_BITS-1:0]   sel_sum;
  logic [DVD_BITS-1:0]   dividend;
  logic [DVS_BITS-1:0]   divisor;
  logic [DVD_BITS-1:0]   quotient;
  logic [DVD_BITS-1:0]   q_sat;
  div_status_t           div_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= size_scale_tenths;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_status.done) begin
          state_next = (ch == CH_H) ? ST_DONE : ST_LOAD;
        end
      end
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    upd       = (state == ST_UPDATE);
    div_start = (state == ST_LOAD);
    cap       = (state == ST_WAIT) && div_status.done;
    out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_x   <= box_x[CW-1:0];
      new_y   <= box_y[CW-1:0];
      new_w   <= box_width[CW-1:0];
      new_h   <= box_height[CW-1:0];
      rd_word <= history[write_slot];
    end
    if (upd) begin
      history[write_slot] <= {new_x, new_y, new_w, new_h};
    end
  end

  assign full = (fill_count == CNT_BITS'(WINDOW));

  // The oldest box leaves the sums only once the window has filled up.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x      <= '0;
      sum_y      <= '0;
      sum_w      <= '0;
      sum_h      <= '0;
      fill_count <= '0;
      write_slot <= '0;
    end else if (upd) begin
      sum_x <= sum_x - (full ? SUM_BITS'(rd_word[4*CW-1:3*CW]) : '0) + SUM_BITS'(new_x);
      sum_y <= sum_y - (full ? SUM_BITS'(rd_word[3*CW-1:2*CW]) : '0) + SUM_BITS'(new_y);
      sum_w <= sum_w - (full ? SUM_BITS'(rd_word[2*CW-1:CW]) : '0) + SUM_BITS'(new_w);
      sum_h <= sum_h - (full ? SUM_BITS'(rd_word[CW-1:0]) : '0) + SUM_BITS'(new_h);
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
      if (write_slot == SLOT_BITS'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
    end
  end

  always_comb begin
    case (ch)
      CH_X:    sel_sum = sum_x;
      CH_Y:    sel_sum = sum_y;
      CH_W:    sel_sum = sum_w;
      CH_H:    sel_sum = sum_h;
      default: sel_sum = sum_x;
    endcase
    scaled_ch = (ch == CH_W) || (ch == CH_H);
    // Width and height divide scale * sum by ten times the count.
    dividend  = scaled_ch ? DVD_BITS'(scale) * DVD_BITS'(sel_sum)
                          : DVD_BITS'(sel_sum);
    divisor   = scaled_ch ? DVS_BITS'({fill_count, 3'b000}) + DVS_BITS'({fill_count, 1'b0})
                          : DVS_BITS'(fill_count);
    q_sat     = (quotient > SAT_MAX) ? SAT_MAX : quotient;
  end

  bbma_div #(
    .DVD_BITS (DVD_BITS),
    .DVS_BITS (DVS_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .status   (div_status),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= CH_X;
    end else if (upd) begin
      ch <= CH_X;
    end else if (cap) begin
      ch <= ch + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      case (ch)
        CH_X:    res_x <= quotient[OF-1:0];
        CH_Y:    res_y <= quotient[OF-1:0];
        CH_W:    res_w <= q_sat[OF-1:0];
        CH_H:    res_h <= q_sat[OF-1:0];
        default: res_x <= quotient[OF-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_x        <= res_x;
      mean_y        <= res_y;
      scaled_width  <= res_w;
      scaled_height <= res_h;
    end
  end

  `BBMA_ASSERT_NEXT(a_accept_starts_update, in_valid && !in_stall, state == ST_UPDATE, "accepted box did not start the update")
  `BBMA_ASSERT_SAME(a_div_done_in_wait, div_status.done, state == ST_WAIT, "divider finished outside the wait state")
  `BBMA_ASSERT_NEXT(a_done_loads_output, state == ST_DONE && (!out_valid || !out_stall), out_valid && state == ST_IDLE, "finished results did not reach the output")
  `BBMA_ASSERT_SAME(a_fill_bounded, upd, fill_count <= CNT_BITS'(WINDOW), "fill count above the window")

endmodule
